// ===== design/w3f_pkg.sv =====
// ----------------------------------------------------------------------------
// w3f_pkg: shared definitions of the 3x3 window image filter
// Register indexes, filter mode codes, reset values and the pixel type.
// ----------------------------------------------------------------------------
package w3f_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Filter mode codes.
  typedef logic [2:0] mode_t;
  localparam mode_t MODE_MEDIAN  = 3'd0;
  localparam mode_t MODE_GAUSS   = 3'd1;
  localparam mode_t MODE_SOBEL_X = 3'd2;
  localparam mode_t MODE_SOBEL_Y = 3'd3;
  localparam mode_t MODE_GREY    = 3'd4;

  // Register reset values.
  localparam logic [10:0] WIDTH_RESET  = 11'd1024;
  localparam logic [15:0] HEIGHT_RESET = 16'd768;

  // Grey value: (r+g+b)/3 as a multiply by 683 and a shift by 11.
  localparam logic [19:0] GREY_RECIP = 20'd683;

  // Largest Sobel magnitude that is passed on.
  localparam logic [9:0] SOBEL_MAX = 10'd255;

  // One pixel, red in the top byte.
  typedef logic [23:0] pixel_t;

  // Per-result control that travels with the window through the pipeline.
  typedef struct packed {
    mode_t mode;
    logic  left_clamp;
    logic  right_ok;
    logic  frame_end;
  } win_ctl_t;

endpackage

// ===== design/w3f_if.sv =====
// ----------------------------------------------------------------------------
// w3f_if: pixel stream channels
// Input channel carries one raster pixel or a drain marker; output channel
// carries one filtered pixel and the end-of-frame flag.
// ----------------------------------------------------------------------------
interface w3f_in_if;
  logic       valid;
  logic       ready;
  logic       drain;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, output drain, output red_in, output green_in,
                  output blue_in, input ready);
  modport sink (input valid, input drain, input red_in, input green_in,
                input blue_in, output ready);
endinterface

interface w3f_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end;

  modport source (output valid, output red_out, output green_out,
                  output blue_out, output frame_end, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input frame_end, output ready);
endinterface

// ===== design/window3x3_image_filter_top.sv =====
// ----------------------------------------------------------------------------
// window3x3_image_filter_top: 3x3 window filter over a raster pixel stream
// Median, Gaussian, Sobel X/Y and grey filters over RGB pixels held in a
// ring of recent pixels, with edge neighbors replaced by the center row or
// column; other mode codes pass the center pixel through.
// ----------------------------------------------------------------------------
// Throughput: one transfer in and one result out per cycle while the output is not stalled.
// A result passes the ring read, window assembly, two sorting and summing stages
// and the output register after the transfer that releases it.
// The ring holds 2*MAX_WIDTH+4 words in two memory copies, one with two read
// ports and one with one, so all three window rows are read together.
// Reset clears positions, counters, configuration registers and the pipeline valid bits;
// the ring is not cleared and is only read where it has been written.
module window3x3_image_filter_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  w3f_in_if.sink                        in_pix,
  w3f_out_if.source                     out_pix,
  input  logic                          cfg_we,
  input  logic [w3f_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [w3f_pkg::CFG_DATA_W-1:0] cfg_data
);
  import w3f_pkg::*;

  localparam int DEPTH = 2 * MAX_WIDTH + 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int EW    = (CW > 11) ? CW : 11;
  localparam int RW    = 16 + CW;
  localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // Ring word: the pixel and the two written before it, oldest on top.
  typedef logic [71:0] word_t;

  function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a,
                                            input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a,
                                            input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      s = s + DEPTH_X;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  // Picks left, center and right pixels of one row from a ring word.
  function automatic logic [71:0] unpack(input word_t wd, input logic lclamp,
                                         input logic rok);
    pixel_t l;
    pixel_t c;
    pixel_t r;
    if (rok) begin
      c = wd[47:24];
      r = wd[23:0];
      l = lclamp ? wd[47:24] : wd[71:48];
    end else begin
      c = wd[23:0];
      r = wd[23:0];
      l = lclamp ? wd[23:0] : wd[47:24];
    end
    return {l, c, r};
  endfunction

  // Configuration registers.
  mode_t       filter_mode;
  logic [10:0] image_width;
  logic [15:0] image_height;

  // Position and ring state.
  logic [CW-1:0] in_column, out_column;
  logic [15:0]   in_row, out_row;
  logic [AW-1:0] write_ptr, pending;
  pixel_t        prev1, prev2;

  // Accept-stage signals.
  logic          advance, acc, pix_write, emit, right_ok, left_clamp, fend;
  logic [CW-1:0] weff, in_column_next, out_column_next;
  logic [15:0]   heff, in_row_next, out_row_next;
  logic [AW-1:0] wp_n, pend_n, pending_next, mid_a, top_a, bot_a;
  pixel_t        px;
  word_t         wdata;

  // Pipeline registers.
  logic     v1, v2, v3, v4, out_valid;
  win_ctl_t ctl1, ctl2, ctl3, ctl4;
  word_t    rd_top, rd_mid, rd_bot, fwd_word;
  logic     hit_top, hit_mid, hit_bot;
  pixel_t   win2 [9];
  logic [9:0] sum2 [9];
  logic [7:0] grey3 [9];
  logic [7:0] lo3 [3][3];
  logic [7:0] mid3 [3][3];
  logic [7:0] hi3 [3][3];
  pixel_t   gauss3, center3, gauss4, center4;
  logic [7:0] mlo4 [3];
  logic [7:0] mmid4 [3];
  logic [7:0] mhi4 [3];
  logic [7:0] sob4, grey4;
  pixel_t   out_px;
  logic     out_fend;

  // Combinational stage results.
  pixel_t   win1 [9];
  logic [7:0] grey2 [9];
  logic [7:0] lo2 [3][3];
  logic [7:0] mid2 [3][3];
  logic [7:0] hi2 [3][3];
  pixel_t   gauss2;
  logic [7:0] mlo3 [3];
  logic [7:0] mmid3 [3];
  logic [7:0] mhi3 [3];
  logic [7:0] sob3;
  pixel_t   result4;

  // The pipeline moves whenever the output register is free or taken.
  assign advance       = !out_valid || out_pix.ready;
  assign in_pix.ready  = advance;
  assign acc           = in_pix.valid && advance;
  assign pix_write     = acc && !in_pix.drain;
  assign px            = {in_pix.red_in, in_pix.green_in, in_pix.blue_in};
  assign wdata         = {prev2, prev1, px};

  // Effective geometry.
  always_comb begin
    logic [EW-1:0] wx;
    wx = EW'(image_width);
    if (image_width == 11'd0) begin
      weff = CW'(1);
    end else if (wx > EW'(MAX_WIDTH)) begin
      weff = CW'(MAX_WIDTH);
    end else begin
      weff = CW'(wx);
    end
    heff = (image_height == 16'd0) ? 16'd1 : image_height;
  end

  // Input side: ring write and input position.
  always_comb begin
    logic [CW:0] col_inc;
    logic [16:0] row_inc;
    col_inc        = {1'b0, in_column} + 1'b1;
    row_inc        = {1'b0, in_row} + 1'b1;
    in_column_next = in_column;
    in_row_next    = in_row;
    wp_n           = write_ptr;
    pend_n         = pending;
    if (pix_write) begin
      wp_n   = (write_ptr == LAST_ADDR) ? '0 : write_ptr + 1'b1;
      pend_n = pending + 1'b1;
      if (col_inc >= {1'b0, weff}) begin
        in_column_next = '0;
        in_row_next    = (row_inc >= {1'b0, heff}) ? 16'd0 : row_inc[15:0];
      end else begin
        in_column_next = col_inc[CW-1:0];
      end
    end
  end

  // Release test and window addresses for the oldest pending pixel.
  always_comb begin
    logic [RW-1:0] recv;
    logic [CW:0]   oc_inc;
    logic [16:0]   or_inc;
    logic [15:0]   lr;
    logic [CW-1:0] lc;
    logic          passed, wrapped, full;
    logic [AW-1:0] base;
    oc_inc = {1'b0, out_column} + 1'b1;
    or_inc = {1'b0, out_row} + 1'b1;
    recv   = RW'(in_row_next) * RW'(weff) + RW'(in_column_next);
    lr     = (or_inc < {1'b0, heff}) ? or_inc[15:0] : heff - 1'b1;
    lc     = (oc_inc < {1'b0, weff}) ? oc_inc[CW-1:0] : weff - 1'b1;
    passed = (in_row_next > lr) || ((in_row_next == lr) && (in_column_next > lc));
    wrapped = RW'(pend_n) > recv;
    full    = (AW + 1)'(pend_n) > ((AW + 1)'(weff) + 1'b1);
    emit    = acc && (pend_n != '0) && (wrapped || passed || full);
    right_ok   = oc_inc < {1'b0, weff};
    left_clamp = (out_column == '0);
    fend       = (out_row == heff - 1'b1) && (out_column == weff - 1'b1);
    base  = sub_mod(wp_n, pend_n);
    mid_a = right_ok ? add_mod(base, AW'(1)) : base;
    top_a = (out_row != 16'd0) ? sub_mod(mid_a, AW'(weff)) : mid_a;
    bot_a = (or_inc < {1'b0, heff}) ? add_mod(mid_a, AW'(weff)) : mid_a;
    out_column_next = out_column;
    out_row_next    = out_row;
    pending_next    = pend_n;
    if (emit) begin
      pending_next = pend_n - 1'b1;
      if (oc_inc >= {1'b0, weff}) begin
        out_column_next = '0;
        out_row_next    = (or_inc >= {1'b0, heff}) ? 16'd0 : or_inc[15:0];
      end else begin
        out_column_next = oc_inc[CW-1:0];
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= MODE_MEDIAN;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_MODE:  filter_mode  <= cfg_data[2:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Position, count and pointer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      write_ptr  <= '0;
      pending    <= '0;
    end else if (acc) begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      write_ptr  <= wp_n;
      pending    <= pending_next;
    end
  end

  // Last two written pixels, packed into each ring word.
  always_ff @(posedge clk) begin
    if (pix_write) begin
      prev1 <= px;
      prev2 <= prev1;
    end
  end

  // Ring copy with two read ports: top and middle rows.
  word_t ring_a [DEPTH];
  always_ff @(posedge clk) begin
    if (pix_write) begin
      ring_a[write_ptr] <= wdata;
    end
    if (advance) begin
      rd_top <= ring_a[top_a];
      rd_mid <= ring_a[mid_a];
    end
  end

  // Ring copy with one read port: bottom row.
  word_t ring_b [DEPTH];
  always_ff @(posedge clk) begin
    if (pix_write) begin
      ring_b[write_ptr] <= wdata;
    end
    if (advance) begin
      rd_bot <= ring_b[bot_a];
    end
  end

  // Forwarding of a word written in the same cycle as it is read.
  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_word <= wdata;
      hit_top  <= pix_write && (top_a == write_ptr);
      hit_mid  <= pix_write && (mid_a == write_ptr);
      hit_bot  <= pix_write && (bot_a == write_ptr);
      ctl1     <= '{mode: filter_mode, left_clamp: left_clamp, right_ok: right_ok,
                    frame_end: fend};
    end
  end

  // Window assembly from the three row words.
  always_comb begin
    logic [71:0] rt, rm, rb;
    rt = unpack(hit_top ? fwd_word : rd_top, ctl1.left_clamp, ctl1.right_ok);
    rm = unpack(hit_mid ? fwd_word : rd_mid, ctl1.left_clamp, ctl1.right_ok);
    rb = unpack(hit_bot ? fwd_word : rd_bot, ctl1.left_clamp, ctl1.right_ok);
    win1[0] = rt[71:48];
    win1[1] = rt[47:24];
    win1[2] = rt[23:0];
    win1[3] = rm[71:48];
    win1[4] = rm[47:24];
    win1[5] = rm[23:0];
    win1[6] = rb[71:48];
    win1[7] = rb[47:24];
    win1[8] = rb[23:0];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl2 <= ctl1;
      for (int i = 0; i < 9; i++) begin
        win2[i] <= win1[i];
        sum2[i] <= 10'(win1[i][23:16]) + 10'(win1[i][15:8]) + 10'(win1[i][7:0]);
      end
    end
  end

  // Grey values, Gaussian sums and row sorts.
  always_comb begin
    logic [19:0] prod;
    logic [7:0]  b [9];
    for (int i = 0; i < 9; i++) begin
      prod     = 20'(sum2[i]) * GREY_RECIP;
      grey2[i] = prod[18:11];
    end
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 9; i++) begin
        b[i] = win2[i][8*c +: 8];
      end
      gauss2[8*c +: 8] = (b[0] >> 4) + (b[2] >> 4) + (b[6] >> 4) + (b[8] >> 4)
                       + (b[1] >> 3) + (b[3] >> 3) + (b[5] >> 3) + (b[7] >> 3)
                       + (b[4] >> 2);
      for (int k = 0; k < 3; k++) begin
        lo2[c][k]  = min3(b[3*k], b[3*k+1], b[3*k+2]);
        mid2[c][k] = med3(b[3*k], b[3*k+1], b[3*k+2]);
        hi2[c][k]  = max3(b[3*k], b[3*k+1], b[3*k+2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl3    <= ctl2;
      gauss3  <= gauss2;
      center3 <= win2[4];
      for (int i = 0; i < 9; i++) begin
        grey3[i] <= grey2[i];
      end
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          lo3[c][k]  <= lo2[c][k];
          mid3[c][k] <= mid2[c][k];
          hi3[c][k]  <= hi2[c][k];
        end
      end
    end
  end

  // Sobel magnitude and the middle step of the median.
  always_comb begin
    logic [9:0] pos, neg, mag;
    if (ctl3.mode == MODE_SOBEL_X) begin
      pos = 10'(grey3[2]) + {1'b0, grey3[5], 1'b0} + 10'(grey3[8]);
      neg = 10'(grey3[0]) + {1'b0, grey3[3], 1'b0} + 10'(grey3[6]);
    end else begin
      pos = 10'(grey3[6]) + {1'b0, grey3[7], 1'b0} + 10'(grey3[8]);
      neg = 10'(grey3[0]) + {1'b0, grey3[1], 1'b0} + 10'(grey3[2]);
    end
    mag  = (pos >= neg) ? pos - neg : neg - pos;
    sob3 = (mag > SOBEL_MAX) ? 8'hff : mag[7:0];
    for (int c = 0; c < 3; c++) begin
      mlo3[c]  = max3(lo3[c][0], lo3[c][1], lo3[c][2]);
      mmid3[c] = med3(mid3[c][0], mid3[c][1], mid3[c][2]);
      mhi3[c]  = min3(hi3[c][0], hi3[c][1], hi3[c][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl4    <= ctl3;
      sob4    <= sob3;
      grey4   <= grey3[4];
      gauss4  <= gauss3;
      center4 <= center3;
      for (int c = 0; c < 3; c++) begin
        mlo4[c]  <= mlo3[c];
        mmid4[c] <= mmid3[c];
        mhi4[c]  <= mhi3[c];
      end
    end
  end

  // Final median step and mode selection.
  always_comb begin
    pixel_t med;
    for (int c = 0; c < 3; c++) begin
      med[8*c +: 8] = med3(mlo4[c], mmid4[c], mhi4[c]);
    end
    case (ctl4.mode)
      MODE_MEDIAN:  result4 = med;
      MODE_GAUSS:   result4 = gauss4;
      MODE_SOBEL_X: result4 = {sob4, sob4, sob4};
      MODE_SOBEL_Y: result4 = {sob4, sob4, sob4};
      MODE_GREY:    result4 = {grey4, grey4, grey4};
      default:      result4 = center4;
    endcase
  end

  // Valid bits of the stages and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= emit;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_px   <= result4;
      out_fend <= ctl4.frame_end;
    end
  end

  assign out_pix.valid     = out_valid;
  assign out_pix.red_out   = out_px[23:16];
  assign out_pix.green_out = out_px[15:8];
  assign out_pix.blue_out  = out_px[7:0];
  assign out_pix.frame_end = out_fend;

endmodule

// ===== design/w3f_check.sv =====
// ----------------------------------------------------------------------------
// w3f_check: port checker for the 3x3 window image filter
// Watches the stream ports and checks output holding and result counts.
// ----------------------------------------------------------------------------
module w3f_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_drain,
  input logic        out_valid,
  input logic        out_ready,
  input logic [24:0] out_data
);

  logic [31:0] pix_count;
  logic [31:0] out_count;

  // Count pixel transfers in and result transfers out.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_count <= '0;
      out_count <= '0;
    end else begin
      if (in_valid && in_ready && !in_drain) begin
        pix_count <= pix_count + 1'b1;
      end
      if (out_valid && out_ready) begin
        out_count <= out_count + 1'b1;
      end
    end
  end

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("result changed while stalled");

  // Every result belongs to a pixel that has already come in.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |-> (out_count < pix_count))
    else $error("more results than pixels");

  // Drain markers alone never raise a result out of an empty block.
  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (pix_count == out_count) |-> !out_valid)
    else $error("result offered with nothing pending");

endmodule

bind window3x3_image_filter_top w3f_check u_w3f_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .in_drain  (in_pix.drain),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .out_data  ({out_pix.frame_end, out_pix.red_out, out_pix.green_out,
               out_pix.blue_out})
);
